FILE: rtl/sbt_pkg.sv
// Shared types, constants and character-class functions for the source byte tokenizer.
package sbt_pkg;

    // Tokenizer modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NUM   = 3'd1,
        MODE_IDENT = 3'd2,
        MODE_STR   = 3'd3,
        MODE_HALT  = 3'd4
    } t_mode;

    // Token kinds
    typedef enum logic [4:0] {
        KIND_NUM    = 5'd0,
        KIND_IDENT  = 5'd1,
        KIND_STRING = 5'd2,
        KIND_PLUS   = 5'd3,
        KIND_MINUS  = 5'd4,
        KIND_STAR   = 5'd5,
        KIND_SLASH  = 5'd6,
        KIND_COMMA  = 5'd7,
        KIND_SEMI   = 5'd8,
        KIND_LPAREN = 5'd9,
        KIND_RPAREN = 5'd10,
        KIND_LBRACE = 5'd11,
        KIND_RBRACE = 5'd12,
        KIND_LBRACK = 5'd13,
        KIND_RBRACK = 5'd14,
        KIND_EOF    = 5'd15,
        KIND_ERROR  = 5'd16
    } t_kind;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNKNOWN_CHAR = 2'd1,
        ERR_SECOND_DOT   = 2'd2,
        ERR_OPEN_STRING  = 2'd3
    } t_err;

    // Request actions
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    // Characters with special meaning
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    localparam int OUT_WIDTH = 32;

    // One result as it sits in the output queue
    typedef struct packed {
        t_kind                 kind;
        logic [OUT_WIDTH-1:0]  begin_pos;
        logic [OUT_WIDTH-1:0]  span_len;
        t_err                  err;
        logic                  last;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Space, TAB, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Single-byte punctuation; KIND_NUM means not punctuation
    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_PLUS: k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;   // '-'
            8'h2A:   k = KIND_STAR;    // '*'
            8'h2F:   k = KIND_SLASH;   // '/'
            8'h2C:   k = KIND_COMMA;   // ','
            CH_SEMI: k = KIND_SEMI;
            8'h28:   k = KIND_LPAREN;  // '('
            8'h29:   k = KIND_RPAREN;  // ')'
            8'h7B:   k = KIND_LBRACE;  // '{'
            8'h7D:   k = KIND_RBRACE;  // '}'
            8'h5B:   k = KIND_LBRACK;  // '['
            8'h5D:   k = KIND_RBRACK;  // ']'
            default: k = KIND_NUM;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/source_byte_tokenizer.sv
// Streaming tokenizer: byte decode, mode state and a four-entry result queue.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  request  | in        | i_valid / o_stall  | i_action, i_char_in
//  result   | out       | o_valid / i_stall  | o_kind, o_begin_pos, o_span_len,
//           |           |                    | o_error_code, o_last
//
// Each request is decoded and the mode state updated in the cycle it is taken; its
// zero, one or two results enter the result queue at that edge and show on the
// result port from the next cycle, one per cycle while i_stall is low.
// A request may be taken every cycle while the queue has room for two results;
// a request that gives two results writes both into the queue at the same edge.
// Reset is synchronous: mode idle, position zero, queue empty.
// o_stall rises when the queue holds three or more results; i_stall holds the head.
module source_byte_tokenizer #(
    parameter int POS_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_kind,
    output logic [31:0] o_begin_pos,
    output logic [31:0] o_span_len,
    output logic [1:0]  o_error_code,
    output logic        o_last
);
    import sbt_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Tokenizer state
    t_mode                r_mode, n_mode;
    logic [POS_WIDTH-1:0] r_start, n_start;
    logic                 r_dot, n_dot;
    logic [POS_WIDTH-1:0] r_pos, n_pos;

    // Result queue
    t_result              r_queue [QDEPTH];
    logic [QAW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [QAW:0]         r_count;

    logic                 accept, pop;
    logic [1:0]           push_n;
    t_result              slot0, slot1;

    // Take low OUT_WIDTH bits of a position, zero-extending narrow ones
    function automatic logic [OUT_WIDTH-1:0] to_out(input logic [POS_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_WIDTH-1:0];
    endfunction

    function automatic t_result make_res(input t_kind k, input logic [POS_WIDTH-1:0] b,
                                         input logic [POS_WIDTH-1:0] l, input t_err e);
        t_result r;
        r.kind      = k;
        r.begin_pos = to_out(b);
        r.span_len  = to_out(l);
        r.err       = e;
        r.last      = 1'b0;
        return r;
    endfunction

    assign o_stall = (r_count > (QAW+1)'(QDEPTH - 2));
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;

    // Decode a byte as if idle
    logic [POS_WIDTH-1:0] cur_len;
    logic                 idle_emit;
    t_result              idle_res;
    t_mode                idle_mode;
    logic [POS_WIDTH-1:0] idle_start;
    logic                 idle_dot;
    t_kind                pk;

    always_comb begin
        pk         = punct_kind(i_char_in);
        idle_emit  = 1'b0;
        idle_res   = make_res(pk, r_pos, POS_WIDTH'(1), ERR_NONE);
        idle_mode  = MODE_IDLE;
        idle_start = r_start;
        idle_dot   = 1'b0;
        if (is_space(i_char_in)) begin
            idle_mode = MODE_IDLE;
        end else if (is_digit(i_char_in) || i_char_in == CH_DOT) begin
            idle_mode  = MODE_NUM;
            idle_start = r_pos;
            idle_dot   = (i_char_in == CH_DOT);
        end else if (is_alpha(i_char_in) || i_char_in == CH_UNDERSCORE) begin
            idle_mode  = MODE_IDENT;
            idle_start = r_pos;
        end else if (i_char_in == CH_QUOTE) begin
            idle_mode  = MODE_STR;
            idle_start = r_pos + POS_WIDTH'(1);
        end else if (pk != KIND_NUM) begin
            idle_emit = 1'b1;
        end else begin
            idle_mode = MODE_HALT;
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_ERROR, r_pos, POS_WIDTH'(1), ERR_UNKNOWN_CHAR);
        end
    end

    // Next state and results: an optional closing token, then an optional second result
    logic    tok_emit, sec_emit;
    t_result tok_res, sec_res;

    always_comb begin
        cur_len  = r_pos - r_start;
        n_mode   = r_mode;
        n_start  = r_start;
        n_dot    = r_dot;
        n_pos    = r_pos;
        tok_emit = 1'b0;
        sec_emit = 1'b0;
        tok_res  = make_res(r_mode == MODE_IDENT ? KIND_IDENT : KIND_NUM,
                            r_start, cur_len, ERR_NONE);
        sec_res  = idle_res;
        if (accept && r_mode != MODE_HALT) begin
            if (i_action == ACT_EOS) begin
                if (r_mode == MODE_STR) begin
                    n_mode   = MODE_HALT;
                    sec_emit = 1'b1;
                    sec_res  = make_res(KIND_ERROR, r_start, cur_len, ERR_OPEN_STRING);
                end else begin
                    tok_emit = (r_mode == MODE_NUM) || (r_mode == MODE_IDENT);
                    n_mode   = MODE_IDLE;
                    n_dot    = 1'b0;
                    sec_emit = 1'b1;
                    sec_res  = make_res(KIND_EOF, r_pos, '0, ERR_NONE);
                end
            end else begin
                n_pos = r_pos + POS_WIDTH'(1);
                unique case (r_mode)
                    MODE_NUM: begin
                        if (i_char_in == CH_DOT) begin
                            if (r_dot) begin
                                n_mode   = MODE_HALT;
                                sec_emit = 1'b1;
                                sec_res  = make_res(KIND_ERROR, r_pos, POS_WIDTH'(1),
                                                    ERR_SECOND_DOT);
                            end else begin
                                n_dot = 1'b1;
                            end
                        end else if (!is_digit(i_char_in)) begin
                            tok_emit = 1'b1;
                            n_mode   = idle_mode;
                            n_start  = idle_start;
                            n_dot    = idle_dot;
                            sec_emit = idle_emit;
                        end
                    end
                    MODE_IDENT: begin
                        if (!(is_alpha(i_char_in) || is_digit(i_char_in) ||
                              i_char_in == CH_UNDERSCORE || i_char_in == CH_HASH)) begin
                            tok_emit = 1'b1;
                            n_mode   = idle_mode;
                            n_start  = idle_start;
                            n_dot    = idle_dot;
                            sec_emit = idle_emit;
                        end
                    end
                    MODE_STR: begin
                        if (i_char_in == CH_QUOTE) begin
                            n_mode   = MODE_IDLE;
                            sec_emit = 1'b1;
                            sec_res  = make_res(KIND_STRING, r_start, cur_len, ERR_NONE);
                        end
                    end
                    MODE_IDLE: begin
                        n_mode   = idle_mode;
                        n_start  = idle_start;
                        n_dot    = idle_dot;
                        sec_emit = idle_emit;
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        end

        // Pack results into queue slots and mark the final one
        tok_res.last = !sec_emit;
        sec_res.last = 1'b1;
        slot1        = sec_res;
        if (tok_emit) begin
            slot0 = tok_res;
        end else begin
            slot0 = sec_res;
        end
        push_n = {1'b0, tok_emit} + {1'b0, sec_emit};
    end

    // Hold tokenizer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_dot   <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_dot   <= n_dot;
            r_pos   <= n_pos;
        end
    end

    // Advance queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QAW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= r_count + (QAW+1)'(push_n) - (QAW+1)'(pop);
        end
    end

    // Write queue entries
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= slot0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + QAW'(1)] <= slot1;
        end
    end

    // Drive result port from queue head
    t_result head;
    assign head         = r_queue[r_rd_ptr];
    assign o_kind       = head.kind;
    assign o_begin_pos  = head.begin_pos;
    assign o_span_len   = head.span_len;
    assign o_error_code = head.err;
    assign o_last       = head.last;

endmodule

FILE: tb/sv/token_checker.sv
// Token checker: watches both channels of the tokenizer, predicts its tokens and compares them.
`timescale 1ns / 100ps

module token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic        i_action,
    input  logic [7:0]  i_char_in,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [4:0]  i_kind,
    input  logic [31:0] i_begin_pos,
    input  logic [31:0] i_span_len,
    input  logic [1:0]  i_error_code,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_outstanding
);
    import sbt_pkg::*;

    // Byte classes as the lexer sees them
    typedef enum logic [2:0] {
        CC_BLANK,
        CC_DIGIT,
        CC_DOT,
        CC_WORD,
        CC_HASH,
        CC_QUOTE,
        CC_PUNCT,
        CC_OTHER
    } t_char_class;

    // Lexer state mirrored from the block
    t_mode       lex_mode;
    logic [31:0] tok_start;
    logic [31:0] cur_pos;
    bit          saw_dot;

    // Tokens predicted but not yet seen on the result port
    t_result     pending_tokens[$];

    // Single-byte tokens; KIND_ERROR stands for "not punctuation"
    function automatic t_kind punct_of(input logic [7:0] c);
        case (c)
            CH_PLUS: return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            ",":     return KIND_COMMA;
            CH_SEMI: return KIND_SEMI;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            "[":     return KIND_LBRACK;
            "]":     return KIND_RBRACK;
            default: return KIND_ERROR;
        endcase
    endfunction

    function automatic t_char_class class_of(input logic [7:0] c);
        // TAB through CR count as blanks
        if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return CC_BLANK;
        if (c >= "0" && c <= "9") return CC_DIGIT;
        if (c == CH_DOT) return CC_DOT;
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE)
            return CC_WORD;
        if (c == CH_HASH) return CC_HASH;
        if (c == CH_QUOTE) return CC_QUOTE;
        if (punct_of(c) != KIND_ERROR) return CC_PUNCT;
        return CC_OTHER;
    endfunction

    function automatic void add_token(input t_kind k, input logic [31:0] b,
                                      input logic [31:0] n, input t_err e);
        t_result r;
        r.kind      = k;
        r.begin_pos = b;
        r.span_len  = n;
        r.err       = e;
        r.last      = 1'b0;
        pending_tokens.push_back(r);
    endfunction

    // Handle a byte with no token open
    function automatic void open_from_idle(input logic [7:0] c, input logic [31:0] at);
        case (class_of(c))
            CC_BLANK: ;
            CC_DIGIT, CC_DOT: begin
                lex_mode  = MODE_NUM;
                tok_start = at;
                saw_dot   = (c == CH_DOT);
            end
            CC_WORD: begin
                lex_mode  = MODE_IDENT;
                tok_start = at;
            end
            CC_QUOTE: begin
                // the span starts after the opening quote
                lex_mode  = MODE_STR;
                tok_start = at + 32'd1;
            end
            CC_PUNCT: add_token(punct_of(c), at, 32'd1, ERR_NONE);
            default: begin
                lex_mode = MODE_HALT;
                add_token(KIND_ERROR, at, 32'd1, ERR_UNKNOWN_CHAR);
            end
        endcase
    endfunction

    // Advance the lexer by one request and queue the tokens it gives
    function automatic void lex_request(input logic act, input logic [7:0] c);
        logic [31:0] here;
        logic [31:0] run_len;
        int          before_n;
        t_char_class cc;
        t_result     tail;
        here     = cur_pos;
        run_len  = here - tok_start;
        before_n = pending_tokens.size();
        cc       = class_of(c);
        if (lex_mode == MODE_HALT) return;
        if (act == ACT_EOS) begin
            if (lex_mode == MODE_STR) begin
                lex_mode = MODE_HALT;
                add_token(KIND_ERROR, tok_start, run_len, ERR_OPEN_STRING);
            end else begin
                if (lex_mode == MODE_NUM)
                    add_token(KIND_NUM, tok_start, run_len, ERR_NONE);
                else if (lex_mode == MODE_IDENT)
                    add_token(KIND_IDENT, tok_start, run_len, ERR_NONE);
                lex_mode = MODE_IDLE;
                saw_dot  = 1'b0;
                add_token(KIND_EOF, here, 32'd0, ERR_NONE);
            end
        end else begin
            cur_pos = here + 32'd1;
            case (lex_mode)
                MODE_NUM: begin
                    if (cc == CC_DOT) begin
                        if (saw_dot) begin
                            lex_mode = MODE_HALT;
                            add_token(KIND_ERROR, here, 32'd1, ERR_SECOND_DOT);
                        end else begin
                            saw_dot = 1'b1;
                        end
                    end else if (cc != CC_DIGIT) begin
                        // close the number, then treat the byte as a fresh one
                        add_token(KIND_NUM, tok_start, run_len, ERR_NONE);
                        lex_mode = MODE_IDLE;
                        saw_dot  = 1'b0;
                        open_from_idle(c, here);
                    end
                end
                MODE_IDENT: begin
                    if (!(cc == CC_WORD || cc == CC_DIGIT || cc == CC_HASH)) begin
                        add_token(KIND_IDENT, tok_start, run_len, ERR_NONE);
                        lex_mode = MODE_IDLE;
                        open_from_idle(c, here);
                    end
                end
                MODE_STR: begin
                    if (cc == CC_QUOTE) begin
                        add_token(KIND_STRING, tok_start, run_len, ERR_NONE);
                        lex_mode = MODE_IDLE;
                    end
                end
                default: begin
                    lex_mode = MODE_IDLE;
                    open_from_idle(c, here);
                end
            endcase
        end
        // mark the final token of this request
        if (pending_tokens.size() > before_n) begin
            tail      = pending_tokens.pop_back();
            tail.last = 1'b1;
            pending_tokens.push_back(tail);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Match one token from the result port against the oldest prediction
    function automatic void check_token();
        t_result want;
        if (pending_tokens.size() == 0) begin
            $error("unexpected token: kind %0d begin_pos %0d span_len %0d",
                   i_kind, i_begin_pos, i_span_len);
            o_fail_count++;
            return;
        end
        want = pending_tokens.pop_front();
        compare_field("kind", 32'(want.kind), 32'(i_kind));
        compare_field("begin_pos", want.begin_pos, i_begin_pos);
        compare_field("span_len", want.span_len, i_span_len);
        compare_field("error_code", 32'(want.err), 32'(i_error_code));
        compare_field("last", 32'(want.last), 32'(i_last));
    endfunction

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // A result never shows in the cycle its request is taken, so check before predicting
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lex_mode  = MODE_IDLE;
            tok_start = '0;
            cur_pos   = '0;
            saw_dot   = 1'b0;
            pending_tokens.delete();
        end else begin
            if (i_res_valid && !i_res_stall) check_token();
            if (i_req_valid && !i_req_stall) lex_request(i_action, i_char_in);
        end
        o_outstanding = pending_tokens.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the tokenizer testbench: clock, reset, source-text stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module testbench;
    import sbt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [7:0]  i_char_in;
    logic        o_valid;
    logic        i_stall;
    logic [4:0]  o_kind;
    logic [31:0] o_begin_pos;
    logic [31:0] o_span_len;
    logic [1:0]  o_error_code;
    logic        o_last;

    int          fail_count;
    int          tokens_outstanding;
    int          items_sent;

    string       punct_chars = "+-*/,;(){}[]";
    logic [7:0]  blank_chars [6] = '{" ", 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    source_byte_tokenizer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_char_in    (i_char_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_begin_pos  (o_begin_pos),
        .o_span_len   (o_span_len),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    token_checker token_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_action      (i_action),
        .i_char_in     (i_char_in),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_kind        (o_kind),
        .i_begin_pos   (o_begin_pos),
        .i_span_len    (o_span_len),
        .i_error_code  (o_error_code),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_outstanding (tokens_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request, idling at random before it (never for requests 700 to 999), and hold it until taken
    task automatic send_request(input logic act, input logic [7:0] c);
        while (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_char_in <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] digit_char();
        logic [7:0] d;
        d = 8'($urandom_range(9));
        return "0" + d;
    endfunction

    // Letter or underscore to open a word; letter, digit, underscore or hash after that
    function automatic logic [7:0] word_char(input bit first);
        int r;
        r = $urandom_range(first ? 52 : 63);
        if (r < 26) return "A" + r[7:0];
        if (r < 52) return "a" + r[7:0] - 8'd26;
        if (first || r == 62) return CH_UNDERSCORE;
        if (r == 63) return CH_HASH;
        return "0" + r[7:0] - 8'd52;
    endfunction

    // Bytes that the lexer accepts with no token open
    function automatic bit is_lexable(input logic [7:0] c);
        int k;
        if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return 1'b1;
        if (c == CH_DOT || c == CH_UNDERSCORE || c == CH_QUOTE) return 1'b1;
        if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            return 1'b1;
        for (k = 0; k < punct_chars.len(); k++)
            if (punct_chars[k] == c) return 1'b1;
        return 1'b0;
    endfunction

    // Result side: random stalls, one long hold-off and one stretch with none
    initial begin
        int cyc;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        for (cyc = 0; ; cyc++) begin
            @(negedge i_clk);
            if (cyc >= 400 && cyc < 700)
                i_stall <= 1'b1;
            else if (cyc >= 1500 && cyc < 2000)
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(99) < 33);
        end
    end

    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int         pick;
        int         span;
        int         dot_at;
        int         k;
        logic [7:0] ch;
        bit         after_number;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = ACT_BYTE;
        i_char_in    = '0;
        items_sent   = 0;
        after_number = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // EOF right after reset; the byte field is ignored
        send_request(ACT_EOS, 8'hFF);
        // string holding the extreme byte values
        send_request(ACT_BYTE, CH_QUOTE);
        send_request(ACT_BYTE, 8'h00);
        send_request(ACT_BYTE, 8'hFF);
        send_request(ACT_BYTE, CH_QUOTE);
        // word closed by punctuation: two tokens from one byte
        send_request(ACT_BYTE, "Z");
        send_request(ACT_BYTE, CH_HASH);
        send_request(ACT_BYTE, CH_PLUS);
        // number opened by a dot, closed by a word
        send_request(ACT_BYTE, CH_DOT);
        send_request(ACT_BYTE, "5");
        send_request(ACT_BYTE, "a");
        // end of source closes the open word before EOF
        send_request(ACT_EOS, 8'h00);
        // rest of the punctuation
        for (k = 1; k < punct_chars.len(); k++)
            send_request(ACT_BYTE, punct_chars[k]);

        // Random source text built from well-formed pieces
        while (items_sent < 1440) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                // keep two numbers apart so their dots never meet
                if (after_number) send_request(ACT_BYTE, " ");
                span   = $urandom_range(1, 6);
                dot_at = $urandom_range(0, span);
                for (k = 0; k < span; k++)
                    send_request(ACT_BYTE, (k == dot_at) ? CH_DOT : digit_char());
            end else if (pick < 40) begin
                span = $urandom_range(0, 5);
                send_request(ACT_BYTE, word_char(1'b1));
                repeat (span) send_request(ACT_BYTE, word_char(1'b0));
            end else if (pick < 52) begin
                span = $urandom_range(0, 8);
                send_request(ACT_BYTE, CH_QUOTE);
                repeat (span) begin
                    do ch = 8'($urandom_range(255)); while (ch == CH_QUOTE);
                    send_request(ACT_BYTE, ch);
                end
                send_request(ACT_BYTE, CH_QUOTE);
            end else if (pick < 72) begin
                send_request(ACT_BYTE, punct_chars[$urandom_range(11)]);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3))
                    send_request(ACT_BYTE, blank_chars[$urandom_range(5)]);
            end else begin
                send_request(ACT_EOS, 8'($urandom_range(255)));
            end
            after_number = (pick < 20);
        end

        // One fatal error ends the stream; the block halts for good
        send_request(ACT_BYTE, " ");
        case ($urandom_range(2))
            0: begin
                do ch = 8'($urandom_range(255)); while (is_lexable(ch));
                send_request(ACT_BYTE, ch);
            end
            1: begin
                repeat ($urandom_range(0, 2)) send_request(ACT_BYTE, digit_char());
                send_request(ACT_BYTE, CH_DOT);
                repeat ($urandom_range(0, 2)) send_request(ACT_BYTE, digit_char());
                send_request(ACT_BYTE, CH_DOT);
            end
            default: begin
                send_request(ACT_BYTE, CH_QUOTE);
                repeat ($urandom_range(0, 4)) begin
                    do ch = 8'($urandom_range(255)); while (ch == CH_QUOTE);
                    send_request(ACT_BYTE, ch);
                end
                send_request(ACT_EOS, 8'($urandom_range(255)));
            end
        endcase
        // halted: these must give nothing
        repeat (8) send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
        i_valid <= 1'b0;

        // Drain, then wait for anything stray
        while (tokens_outstanding != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
